// ===== rtl/core/tccp_pkg.sv =====
// ----------------------------------------------------------------------------
// tccp_pkg: shared types and constants of the triangle geometry stage
// Q16.16 formats, request/result payloads, divider stage state and codes.
// ----------------------------------------------------------------------------
package tccp_pkg;

  localparam int unsigned Q_W        = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned CLIP_W     = 49;
  localparam int unsigned MAG_W      = 48;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned AREA_W     = 67;
  localparam int unsigned DIV_STAGES = 32;
  localparam int unsigned NUM_COORD  = 9;
  localparam int unsigned PADDR_W    = 3;

  localparam logic signed [Q_W-1:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [Q_W-1:0] Q_NEG_ONE = -32'sh0001_0000;
  localparam logic signed [Q_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN     = 32'sh8000_0000;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TRI  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_KEPT   = 2'd0;
  localparam logic [1:0] STATUS_BEHIND = 2'd1;
  localparam logic [1:0] STATUS_DEPTH  = 2'd2;
  localparam logic [1:0] STATUS_CULLED = 2'd3;

  // register index of front_is_clockwise (taken from paddr[2])
  localparam logic REG_FRONT_CW = 1'b0;

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [CLIP_W-1:0] clip_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] entry_index;
    q_t         entry_value;
    q_t         a_x;
    q_t         a_y;
    q_t         a_z;
    q_t         b_x;
    q_t         b_y;
    q_t         b_z;
    q_t         c_x;
    q_t         c_y;
    q_t         c_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    q_t         ndc_a_x;
    q_t         ndc_a_y;
    q_t         ndc_a_z;
    q_t         ndc_b_x;
    q_t         ndc_b_y;
    q_t         ndc_b_z;
    q_t         ndc_c_x;
    q_t         ndc_c_y;
    q_t         ndc_c_z;
  } out_item_t;

  // one perspective-divide request: |clip| and w, both below 2^48
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] w;
    logic             neg;
    logic             ovf;
  } div_req_t;

  // state of one restoring-division stage
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [Q_W-1:0]   lo;
    logic [Q_W-1:0]   quo;
    logic [MAG_W-1:0] w;
    logic             neg;
    logic             ovf;
  } div_st_t;

  // control that travels beside the divider lanes
  typedef struct packed {
    logic valid;
    logic behind;
  } side_t;

endpackage

// ===== rtl/core/tccp_xform.sv =====
// ----------------------------------------------------------------------------
// tccp_xform: matrix store and vertex transform
// Holds the 4x4 matrix, multiplies three vertices by it and sets up the
// nine perspective-divide requests. Three register stages.
// ----------------------------------------------------------------------------
module tccp_xform (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               take,
  input  tccp_pkg::in_item_t item,
  output tccp_pkg::div_req_t req [tccp_pkg::NUM_COORD],
  output tccp_pkg::side_t    side
);
  import tccp_pkg::*;

  q_t                        mtx [16];
  q_t                        obj [3][3];
  logic signed [PROD_W-1:0]  prod [3][4][3];
  q_t                        tr [4];
  logic                      s1_valid;
  logic signed [PROD_W-1:0]  csum [3][4];
  clip_t                     clip [3][4];
  logic                      s2_valid;
  div_req_t                  req_next [NUM_COORD];
  logic                      behind_next;

  // object-space coordinates of the request
  always_comb begin
    obj[0][0] = item.a_x; obj[0][1] = item.a_y; obj[0][2] = item.a_z;
    obj[1][0] = item.b_x; obj[1][1] = item.b_y; obj[1][2] = item.b_z;
    obj[2][0] = item.c_x; obj[2][1] = item.c_y; obj[2][2] = item.c_z;
  end

  // matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mtx[i] <= (i % 5 == 0) ? Q_ONE : '0;
      end
    end else if (take && item.kind == KIND_LOAD) begin
      mtx[item.entry_index] <= item.entry_value;
    end
  end

  // stage 1: products of matrix entries and coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= take && item.kind == KIND_TRI;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 3; c++) begin
            prod[v][r][c] <= mtx[r + 4 * c] * obj[v][c];
          end
        end
      end
      for (int r = 0; r < 4; r++) begin
        tr[r] <= mtx[r + 12];
      end
    end
  end

  // stage 2: floor-shift products and add translation
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int r = 0; r < 4; r++) begin
        csum[v][r] = PROD_W'(tr[r]) + (prod[v][r][0] >>> FRAC_BITS)
                   + (prod[v][r][1] >>> FRAC_BITS) + (prod[v][r][2] >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int r = 0; r < 4; r++) begin
          clip[v][r] <= csum[v][r][CLIP_W-1:0];
        end
      end
    end
  end

  // stage 3: w test, magnitudes and quotient overflow check
  always_comb begin
    logic signed [CLIP_W-1:0] x;
    logic signed [CLIP_W-1:0] m;
    behind_next = 1'b0;
    for (int v = 0; v < 3; v++) begin
      if (clip[v][3] <= 0) begin
        behind_next = 1'b1;
      end
    end
    for (int k = 0; k < NUM_COORD; k++) begin
      x = clip[k / 3][k % 3];
      m = x[CLIP_W-1] ? -x : x;
      req_next[k].neg = x[CLIP_W-1];
      req_next[k].mag = m[MAG_W-1:0];
      req_next[k].w   = clip[k / 3][3][MAG_W-1:0];
      req_next[k].ovf = {16'h0000, m[MAG_W-1:0]} >= {clip[k / 3][3][MAG_W-1:0], 16'h0000};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else if (en) begin
      side.valid  <= s2_valid;
      side.behind <= behind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_COORD; k++) begin
        req[k] <= req_next[k];
      end
    end
  end

endmodule

// ===== rtl/core/tccp_div.sv =====
// ----------------------------------------------------------------------------
// tccp_div: pipelined perspective divide
// Restoring division of |clip| * 2^16 by w, one quotient bit per stage,
// with signed saturation to Q16.16 on the last stage.
// ----------------------------------------------------------------------------
module tccp_div (
  input  logic               clk,
  input  logic               en,
  input  tccp_pkg::div_req_t req,
  output tccp_pkg::q_t       quo
);
  import tccp_pkg::*;

  div_st_t st0;
  div_st_t stg [DIV_STAGES];
  div_st_t last;

  // upper dividend word seeds the remainder, lower word shifts in
  always_comb begin
    st0.rem = {16'h0000, req.mag[MAG_W-1:FRAC_BITS]};
    st0.lo  = {req.mag[FRAC_BITS-1:0], 16'h0000};
    st0.quo = '0;
    st0.w   = req.w;
    st0.neg = req.neg;
    st0.ovf = req.ovf;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_st_t          cur;
    div_st_t          nxt;
    logic [MAG_W:0]   t;
    logic [MAG_W:0]   d;
    logic             ge;

    if (k == 0) begin : g_first
      assign cur = st0;
    end else begin : g_rest
      assign cur = stg[k-1];
    end

    // compare and subtract one bit
    always_comb begin
      t   = {cur.rem, cur.lo[Q_W-1]};
      d   = t - {1'b0, cur.w};
      ge  = t >= {1'b0, cur.w};
      nxt = cur;
      nxt.rem = ge ? d[MAG_W-1:0] : t[MAG_W-1:0];
      nxt.lo  = {cur.lo[Q_W-2:0], 1'b0};
      nxt.quo = {cur.quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg[k] <= nxt;
      end
    end
  end

  assign last = stg[DIV_STAGES-1];

  // saturate and apply sign
  always_comb begin
    if (last.neg) begin
      quo = (last.ovf || last.quo > 32'h8000_0000) ? Q_MIN : -$signed(last.quo);
    end else begin
      quo = (last.ovf || last.quo[Q_W-1]) ? Q_MAX : $signed(last.quo);
    end
  end

endmodule

// ===== rtl/core/tccp_cull.sv =====
// ----------------------------------------------------------------------------
// tccp_cull: depth test and back-face cull
// Registers the NDC values, checks depth, forms the shoelace products and
// resolves the final status. Three register stages.
// ----------------------------------------------------------------------------
module tccp_cull (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                front_cw,
  input  tccp_pkg::side_t     side,
  input  tccp_pkg::q_t        ndc [tccp_pkg::NUM_COORD],
  output logic                res_valid,
  output tccp_pkg::out_item_t res
);
  import tccp_pkg::*;

  q_t                        na [NUM_COORD];
  logic [1:0]                sa;
  logic                      va;
  q_t                        nb [NUM_COORD];
  logic [1:0]                sb;
  logic                      vb;
  logic signed [PROD_W-1:0]  pr [6];
  q_t                        nc [NUM_COORD];
  logic [1:0]                sc;
  logic                      vc;
  logic                      depth_bad;
  logic signed [AREA_W-1:0]  area;
  logic                      cull;

  // stage A: NDC values and depth test
  always_comb begin
    depth_bad = 1'b0;
    for (int v = 0; v < 3; v++) begin
      if (ndc[3 * v + 2] < Q_NEG_ONE || ndc[3 * v + 2] > Q_ONE) begin
        depth_bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na <= ndc;
      priority if (side.behind) begin
        sa <= STATUS_BEHIND;
      end else if (depth_bad) begin
        sa <= STATUS_DEPTH;
      end else begin
        sa <= STATUS_KEPT;
      end
    end
  end

  // stage B: shoelace cross products
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr[2 * i]     <= na[3 * i] * na[3 * ((i + 1) % 3) + 1];
        pr[2 * i + 1] <= na[3 * ((i + 1) % 3)] * na[3 * i + 1];
      end
      nb <= na;
      sb <= sa;
    end
  end

  // stage C: exact area sign and final status
  always_comb begin
    area = AREA_W'(pr[0]) - AREA_W'(pr[1]) + AREA_W'(pr[2]) - AREA_W'(pr[3])
         + AREA_W'(pr[4]) - AREA_W'(pr[5]);
    if (front_cw) begin
      cull = !area[AREA_W-1] && area != 0;
    end else begin
      cull = area[AREA_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nc <= nb;
      sc <= (sb == STATUS_KEPT && cull) ? STATUS_CULLED : sb;
    end
  end

  // drop coordinates of rejected triangles
  always_comb begin
    res_valid = vc;
    res       = '0;
    res.status = sc;
    if (sc == STATUS_KEPT) begin
      res.ndc_a_x = nc[0]; res.ndc_a_y = nc[1]; res.ndc_a_z = nc[2];
      res.ndc_b_x = nc[3]; res.ndc_b_y = nc[4]; res.ndc_b_z = nc[5];
      res.ndc_c_x = nc[6]; res.ndc_c_y = nc[7]; res.ndc_c_z = nc[8];
    end
  end

endmodule

// ===== rtl/core/triangle_clip_cull_project.sv =====
// ----------------------------------------------------------------------------
// triangle_clip_cull_project: triangle transform, divide and cull
// Top level: APB register, input acceptance, divider lanes, output skid.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready/in_data. A load request (kind 0)
//   writes one column-major matrix entry and yields no result. A triangle
//   request (kind 1) yields exactly one result on out_valid/out_ready/
//   out_data: status plus NDC x, y, z of the three vertices (zero unless
//   the triangle is kept).
//   Throughput: one request per cycle while in_ready is high. A triangle
//   passes through three transform stages (the accepting edge loads the
//   first), 32 divider stages (one quotient bit each), three cull stages
//   and the output register before it shows on out_data.
//   Load requests write the matrix at acceptance, so any triangle accepted
//   afterwards uses the new entry.
//   Reset (rst, synchronous) empties the pipeline, restores the identity
//   matrix and sets front_is_clockwise to 1 (APB address 0).
//   When a result arrives while out_valid is high and out_ready low, it
//   moves into a skid register and in_ready drops until the skid register drains.
// ----------------------------------------------------------------------------
module triangle_clip_cull_project (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tccp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tccp_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tccp_pkg::out_item_t           out_data
);
  import tccp_pkg::*;

  logic       front_cw;
  logic       adv;
  logic       take;
  div_req_t   req [NUM_COORD];
  side_t      side_x;
  side_t      side_d [DIV_STAGES];
  q_t         ndc [NUM_COORD];
  logic       res_valid;
  out_item_t  res;
  logic       skid_valid;
  out_item_t  skid;
  logic       out_take;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_cw <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_FRONT_CW) begin
      front_cw <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRONT_CW) begin
      prdata[0] = front_cw;
    end
  end

  // pipeline advances while the skid register is empty
  assign adv      = !skid_valid;
  assign in_ready = adv;
  assign take     = in_valid && adv;

  tccp_xform u_xform (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .take (take),
    .item (in_data),
    .req  (req),
    .side (side_x)
  );

  for (genvar k = 0; k < NUM_COORD; k++) begin : g_lane
    tccp_div u_div (
      .clk (clk),
      .en  (adv),
      .req (req[k]),
      .quo (ndc[k])
    );
  end

  // carry valid and w flag beside the divider lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        side_d[i] <= '0;
      end
    end else if (adv) begin
      side_d[0] <= side_x;
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  tccp_cull u_cull (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .front_cw  (front_cw),
    .side      (side_d[DIV_STAGES-1]),
    .ndc       (ndc),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register with skid
  assign out_take = out_ready || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid;
      end
    end else if (res_valid) begin
      if (out_take) begin
        out_data <= res;
      end else begin
        skid <= res;
      end
    end
  end

endmodule

// ===== rtl/core/tccp_checker.sv =====
// ----------------------------------------------------------------------------
// tccp_checker: port-level checks of the triangle geometry stage
// Watches reset behavior, result stability, rejected-result coding, kept depth.
// ----------------------------------------------------------------------------
module tccp_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tccp_pkg::out_item_t out_data
);
  import tccp_pkg::*;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // reset leaves the block ready for requests
  a_rst_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("not ready after reset");

  // rejected triangles carry no coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_KEPT |->
      out_data.ndc_a_x == 0 && out_data.ndc_a_y == 0 && out_data.ndc_a_z == 0 &&
      out_data.ndc_b_x == 0 && out_data.ndc_b_y == 0 && out_data.ndc_b_z == 0 &&
      out_data.ndc_c_x == 0 && out_data.ndc_c_y == 0 && out_data.ndc_c_z == 0)
    else $error("rejected result with coordinates");

  // kept triangles lie inside the depth range
  a_kept_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_KEPT |->
      out_data.ndc_a_z >= Q_NEG_ONE && out_data.ndc_a_z <= Q_ONE &&
      out_data.ndc_b_z >= Q_NEG_ONE && out_data.ndc_b_z <= Q_ONE &&
      out_data.ndc_c_z >= Q_NEG_ONE && out_data.ndc_c_z <= Q_ONE)
    else $error("kept result outside depth range");

endmodule

bind triangle_clip_cull_project tccp_checker u_tccp_checker (.*);
